/* design/hmr_pkg.sv */
// Package for the histogram matching remap block.
// Holds command codes, result kinds and payload types; no dependencies.
`default_nettype none
package hmr_pkg;
  localparam int unsigned FuncBits  = 3;
  localparam int unsigned PixelBits = 8;

  typedef enum logic [FuncBits-1:0] {
    FUNC_ADD_IN  = 3'd0,
    FUNC_ADD_REF = 3'd1,
    FUNC_BUILD   = 3'd2,
    FUNC_MAP     = 3'd3,
    FUNC_CLEAR   = 3'd4
  } func_e;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_PIXEL  = 1'b1;

  localparam logic [PixelBits-1:0] STATUS_OK    = 8'd0;
  localparam logic [PixelBits-1:0] STATUS_EMPTY = 8'd1;

  typedef struct packed {
    logic [FuncBits-1:0]  func;
    logic [PixelBits-1:0] pixel;
  } in_item_t;

  typedef struct packed {
    logic                 kind;
    logic [PixelBits-1:0] value;
  } out_item_t;
endpackage
`default_nettype wire

/* design/hmr_in_if.sv */
// Input channel interface: valid, ready and one command transaction.
// Depends on hmr_pkg.
`default_nettype none
interface hmr_in_if;
  logic             valid;
  logic             ready;
  hmr_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* design/hmr_out_if.sv */
// Output channel interface: valid, ready and one result transaction.
// Depends on hmr_pkg.
`default_nettype none
interface hmr_out_if;
  logic              valid;
  logic              ready;
  hmr_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* design/histogram_matching_remap.sv */
// Top level of the histogram matching remap block.
// Depends on hmr_pkg, hmr_in_if and hmr_out_if.
//
// Usage: commands arrive on in_i (func, pixel); results leave on out_o (kind, value).
// Add commands update one histogram bin and its total by read-modify-write in
// a synchronous memory.
// Map commands read the level map memory into a read register; the mapped pixel
// then goes to the output register.
// Build walks the histograms: one pass for totals and the cumulative reference
// table, then for every input level a scan of LEVELS reference levels, one
// compare a cycle through a two-stage multiply and compare pipeline, ending in
// the status result; with an empty histogram the status is STATUS_EMPTY instead.
// Clear sweeps both histograms, one entry a cycle.
// After reset a clearing pass zeroes histograms and map;
// no command is taken until it ends.
// A result waits in an output register; while the receiver stalls, the block
// accepts no further command until the result is taken.
`default_nettype none
module histogram_matching_remap #(
  parameter int unsigned LEVELS     = 256,
  parameter int unsigned COUNT_BITS = 23
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  hmr_in_if.sink     in_i,
  hmr_out_if.source  out_o
);
  localparam int unsigned AW = $clog2(LEVELS);
  localparam int unsigned PW = hmr_pkg::PixelBits;
  localparam int unsigned CW = COUNT_BITS;
  localparam int unsigned SW = CW + AW;
  localparam int unsigned PRW = 2 * SW;
  localparam logic [CW-1:0] CMAX = {CW{1'b1}};
  localparam logic [AW:0] LAST = (AW+1)'(LEVELS - 1);

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_ADD_RD, ST_ADD_WR, ST_MAP_RD, ST_CLEAR,
    ST_SUM, ST_SUM_END, ST_ROW, ST_SCAN, ST_DRAIN, ST_RESP
  } state_e;

  logic [CW-1:0] hin_mem [LEVELS];
  logic [CW-1:0] href_mem [LEVELS];
  logic [SW-1:0] cum_mem [LEVELS];
  logic [AW-1:0] map_mem [LEVELS];

  state_e state_q;
  logic [AW:0] idx_q, jdx_q;
  logic sel_ref_q;
  logic [CW-1:0] tin_q, tref_q;
  logic [SW-1:0] ta_q, tb_q, ca_q, cb_q;
  logic [CW-1:0] hin_rd_q, href_rd_q;
  logic [SW-1:0] cum_rd_q;
  logic [AW-1:0] map_rd_q, px_q, pick_q;
  logic [PRW-1:0] lhs_q, best_q, prod_q;
  logic [AW-1:0] pj_q;
  logic pv_q, rv_q;
  logic [AW:0] row_j_q;
  logic out_valid_q;
  hmr_pkg::out_item_t out_q;

  // memory controls
  logic rd_en;
  logic [AW-1:0] rd_a, jrd_a;
  logic hin_we, href_we, cum_we, map_we;
  logic [AW-1:0] wa;
  logic [CW-1:0] hin_wd, href_wd;
  logic [SW-1:0] cum_wd;
  logic [AW-1:0] map_wd;

  logic in_fire;
  assign in_i.ready = (state_q == ST_IDLE) && !out_valid_q;
  assign in_fire = in_i.valid && in_i.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data = out_q;

  logic px_ok;
  logic [AW-1:0] px_in;
  assign px_ok = {{(32-PW){1'b0}}, in_i.data.pixel} < 32'(LEVELS);
  assign px_in = px_ok ? AW'(in_i.data.pixel) : AW'(LEVELS - 1);

  always_ff @(posedge clk_i) begin
    if (hin_we) hin_mem[wa] <= hin_wd;
    if (href_we) href_mem[wa] <= href_wd;
    if (cum_we) cum_mem[wa] <= cum_wd;
    if (map_we) map_mem[wa] <= map_wd;
    if (rd_en) begin
      hin_rd_q <= hin_mem[rd_a];
      href_rd_q <= href_mem[rd_a];
      map_rd_q <= map_mem[rd_a];
    end
    cum_rd_q <= cum_mem[jrd_a];
  end

  always_comb begin
    rd_en = 1'b0; rd_a = idx_q[AW-1:0]; jrd_a = jdx_q[AW-1:0];
    hin_we = 1'b0; href_we = 1'b0; cum_we = 1'b0; map_we = 1'b0;
    wa = idx_q[AW-1:0];
    hin_wd = '0; href_wd = '0; cum_wd = '0; map_wd = '0;
    case (state_q)
      ST_INIT: begin
        hin_we = 1'b1; href_we = 1'b1; map_we = 1'b1;
      end
      ST_IDLE: begin
        rd_en = in_fire; rd_a = px_in;
      end
      ST_ADD_WR: begin
        wa = px_q;
        hin_we = !sel_ref_q && hin_rd_q != CMAX;
        href_we = sel_ref_q && href_rd_q != CMAX;
        hin_wd = hin_rd_q + CW'(1);
        href_wd = href_rd_q + CW'(1);
      end
      ST_CLEAR: begin
        hin_we = 1'b1; href_we = 1'b1;
      end
      ST_SUM: rd_en = 1'b1;
      ST_SUM_END: begin
        wa = jdx_q[AW-1:0];
        cum_we = 1'b1; cum_wd = cb_q + href_rd_q;
        rd_en = 1'b1; rd_a = idx_q[AW-1:0];
      end
      ST_ROW: begin
        rd_en = 1'b1;
      end
      ST_DRAIN: begin
        wa = row_j_q[AW-1:0];
        map_we = !pv_q && !rv_q;
        map_wd = pick_q;
      end
      default: ;
    endcase
  end

  // distance of current product against lhs
  logic [PRW-1:0] gap;
  assign gap = (lhs_q < prod_q) ? prod_q - lhs_q : lhs_q - prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      idx_q <= '0; jdx_q <= '0;
      sel_ref_q <= 1'b0;
      tin_q <= '0; tref_q <= '0;
      out_valid_q <= 1'b0;
      pv_q <= 1'b0; rv_q <= 1'b0;
      row_j_q <= '0;
    end else begin
      if (out_valid_q && out_o.ready) out_valid_q <= 1'b0;
      case (state_q)
        ST_INIT: begin
          if (idx_q == LAST) begin
            idx_q <= '0; state_q <= ST_IDLE;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        ST_IDLE: if (in_fire) begin
          px_q <= px_in;
          case (in_i.data.func)
            hmr_pkg::FUNC_ADD_IN, hmr_pkg::FUNC_ADD_REF: begin
              sel_ref_q <= in_i.data.func == hmr_pkg::FUNC_ADD_REF;
              if (px_ok) state_q <= ST_ADD_RD;
            end
            hmr_pkg::FUNC_MAP: state_q <= ST_MAP_RD;
            hmr_pkg::FUNC_CLEAR: begin
              idx_q <= '0; tin_q <= '0; tref_q <= '0; state_q <= ST_CLEAR;
            end
            hmr_pkg::FUNC_BUILD: begin
              if (tin_q == '0 || tref_q == '0) begin
                out_q <= '{kind: hmr_pkg::KIND_STATUS, value: hmr_pkg::STATUS_EMPTY};
                out_valid_q <= 1'b1;
              end else begin
                idx_q <= '0; jdx_q <= '0; ta_q <= '0; cb_q <= '0;
                state_q <= ST_SUM;
              end
            end
            default: ;
          endcase
        end
        ST_ADD_RD: state_q <= ST_ADD_WR;
        ST_ADD_WR: begin
          if (!sel_ref_q && tin_q != CMAX) tin_q <= tin_q + CW'(1);
          if (sel_ref_q && tref_q != CMAX) tref_q <= tref_q + CW'(1);
          state_q <= ST_IDLE;
        end
        ST_MAP_RD: begin
          out_q <= '{kind: hmr_pkg::KIND_PIXEL, value: PW'(map_rd_q)};
          out_valid_q <= 1'b1;
          state_q <= ST_IDLE;
        end
        ST_CLEAR: begin
          idx_q <= idx_q + 1'b1;
          if (idx_q == LAST) state_q <= ST_IDLE;
        end
        ST_SUM: begin
          // reads of entry idx arrive next cycle
          idx_q <= idx_q + 1'b1;
          jdx_q <= idx_q;
          state_q <= ST_SUM_END;
        end
        ST_SUM_END: begin
          ta_q <= ta_q + hin_rd_q;
          cb_q <= cb_q + href_rd_q;
          if (jdx_q == LAST) begin
            tb_q <= cb_q + href_rd_q;
            idx_q <= '0; ca_q <= '0;
            state_q <= ST_ROW;
          end else begin
            idx_q <= idx_q + 1'b1;
            jdx_q <= idx_q;
          end
        end
        ST_ROW: begin
          // hin_rd_q holds bin idx-1 from the previous read; fetch row idx
          state_q <= ST_SCAN;
          jdx_q <= '0;
        end
        ST_SCAN: begin
          if (jdx_q == '0) begin
            ca_q <= ca_q + hin_rd_q;
            lhs_q <= (PRW)'(ca_q + hin_rd_q) * (PRW)'(tb_q);
            best_q <= (PRW)'(ta_q) * (PRW)'(tb_q);
            pick_q <= '0;
          end
          rv_q <= 1'b1;
          pj_q <= jdx_q[AW-1:0];
          pv_q <= rv_q;
          if (rv_q) prod_q <= (PRW)'(cum_rd_q) * (PRW)'(ta_q);
          if (pv_q && gap < best_q) begin
            best_q <= gap; pick_q <= pj_q - AW'(1);
          end
          jdx_q <= jdx_q + 1'b1;
          if (jdx_q == LAST) begin
            state_q <= ST_DRAIN; row_j_q <= idx_q;
          end
        end
        ST_DRAIN: begin
          pv_q <= rv_q;
          rv_q <= 1'b0;
          if (rv_q) prod_q <= (PRW)'(cum_rd_q) * (PRW)'(ta_q);
          if (pv_q && gap < best_q) begin
            best_q <= gap;
            pick_q <= pj_q - AW'(1);
          end
          if (rv_q) pj_q <= pj_q + AW'(1);
          if (!pv_q && !rv_q) begin
            if (row_j_q == LAST) begin
              out_q <= '{kind: hmr_pkg::KIND_STATUS, value: hmr_pkg::STATUS_OK};
              out_valid_q <= 1'b1;
              state_q <= ST_RESP;
            end else begin
              idx_q <= row_j_q + 1'b1;
              state_q <= ST_ROW;
            end
          end
        end
        ST_RESP: state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !in_i.ready) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=> (out_o.valid && $stable(out_o.data)))
    else $error("result dropped");
  a_tot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROW) |-> (ta_q >= SW'(tin_q) && tb_q >= SW'(tref_q)))
    else $error("bin sums below totals");
`endif
endmodule
`default_nettype wire
